[hdl/lae_pkg.sv]
// Package for the latency average extrapolator: beat types, divider control
// structs and fixed constants. No dependencies.
package lae_pkg;

	localparam int unsigned LAT_W  = 32;   // latency and average width
	localparam int unsigned TS_W   = 64;   // timestamp width
	localparam int unsigned POS_W  = 32;   // Q16.16 position / velocity
	localparam int unsigned DQ_W   = 64;   // divider dividend/quotient register
	localparam int unsigned DIV_W  = 30;   // divisor/remainder width (1e9 < 2^30)
	localparam int unsigned STEP_W = 7;    // divider step counter, holds DQ_W

	localparam logic [DIV_W-1:0] NS_PER_SEC      = 30'd1000000000;
	localparam logic [LAT_W-1:0] DEFAULT_LAT_RST = 32'd50000000;

	localparam logic MODE_LOG     = 1'b0;
	localparam logic MODE_PREDICT = 1'b1;

	typedef struct packed {
		logic                    mode;
		logic [TS_W-1:0]         capture_ts;
		logic [TS_W-1:0]         arrival_ts;
		logic signed [POS_W-1:0] position_now;
		logic signed [POS_W-1:0] velocity;
	} item_t;

	typedef struct packed {
		logic [LAT_W-1:0]        average_latency_ns;
		logic signed [POS_W-1:0] predicted_position;
	} result_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

[hdl/latency_average_extrapolator.sv]
// Top level: sliding-window latency averager with Q16.16 position extrapolation.
// Depends on lae_pkg, lae_ram, lae_serdiv.
//
//  channel | dir | handshake                | beat
//  --------+-----+--------------------------+----------------------------------
//  item    | in  | item_valid / item_ready  | lae_pkg::item_t (mode, times, pos)
//  result  | out | result_valid/result_ready| lae_pkg::result_t (avg, position)
//  cfg     | in  | cfg_valid / cfg_ready    | default_latency_ns, 32 bits
//
// One item at a time. Log beat (mode 0): its time is set by the bit-serial average
// divide of the window sum by the count. Predict beat (mode 1): the 64-step divide
// of velocity*average by 1e9 in the same serial divider dominates. An empty window
// skips the average divide. A finished result sits in the output register while
// the next beat is taken; the block only stalls in its last state if that register
// is still full. Reset clears sum, count and write slot and loads the default
// register with 50 ms; the ring itself is never cleared, and a read entry is only
// used once the window is full, so once it has been written.
module latency_average_extrapolator #(
	parameter int unsigned WINDOW_DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  lae_pkg::item_t              item,
	output logic                        result_valid,
	input  logic                        result_ready,
	output lae_pkg::result_t            result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lae_pkg::LAT_W-1:0]   cfg_data
);
	import lae_pkg::*;

	localparam int unsigned SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
	// DEPTH * (2^32 - 1) < 2^(32 + clog2(DEPTH))
	localparam int unsigned SUM_W  = LAT_W + $clog2(WINDOW_DEPTH);
	localparam int unsigned Q_W    = 34;   // velocity*avg/1e9 < 2^34
	localparam int unsigned ACC_W  = 36;   // position plus distance, no wrap

	localparam logic signed [ACC_W-1:0] POS_MAX = 36'sd2147483647;
	localparam logic signed [ACC_W-1:0] POS_MIN = -36'sd2147483648;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,  // waiting for an item beat
		ST_LOG  = 7'b0000010,  // ring data back: update sum, count, slot
		ST_AVG  = 7'b0000100,  // start average divide or take the default
		ST_AVGW = 7'b0001000,  // average divide running
		ST_MUL  = 7'b0010000,  // multiply |velocity| * avg, start divide by 1e9
		ST_XW   = 7'b0100000,  // extrapolation divide running
		ST_DONE = 7'b1000000   // hand result to the output register
	} state_t;

	state_t state_q;

	// beat payload held for the whole item
	logic                    mode_q;
	logic signed [POS_W-1:0] pos_q;
	logic signed [POS_W-1:0] vel_q;
	logic [LAT_W-1:0]        lat_q;

	// window state
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SLOT_W-1:0] slot_q;
	logic [LAT_W-1:0]  default_q;

	logic [LAT_W-1:0]        avg_q;
	logic signed [POS_W-1:0] pos_res_q;
	result_t                 out_q;
	logic                    out_valid_q;

	logic item_acc;
	logic out_load;

	// latency from the incoming beat: clamp negative to 0, saturate above 32 bits
	logic [TS_W-1:0]  lat_diff;
	logic [LAT_W-1:0] lat_new;

	// ring
	logic             ram_we;
	logic             ram_re;
	logic [LAT_W-1:0] old_lat;

	logic             full;
	logic [SUM_W-1:0] sum_drop;
	logic [SUM_W-1:0] sum_next;

	// extrapolation datapath
	logic [POS_W-1:0]        vel_u;
	logic [POS_W-1:0]        mag;
	logic [DQ_W-1:0]         prod;
	logic [DQ_W-1:0]         quotient;
	logic [Q_W-1:0]          q_dist;
	logic signed [ACC_W-1:0] travel;
	logic signed [ACC_W-1:0] pos_ext;
	logic signed [ACC_W-1:0] pos_sum;
	logic signed [POS_W-1:0] pos_sat;

	// divider control
	div_req_t         div_req;
	div_sts_t         div_sts;
	logic [DQ_W-1:0]  div_dividend;
	logic [DIV_W-1:0] div_divisor;

	assign item_ready = (state_q == ST_IDLE);
	assign item_acc   = item_valid && item_ready;
	assign cfg_ready  = 1'b1;
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || result_ready);

	always_comb begin
		lat_diff = item.arrival_ts - item.capture_ts;
		if (item.arrival_ts < item.capture_ts) begin
			lat_new = '0;
		end else if (|lat_diff[TS_W-1:LAT_W]) begin
			lat_new = '1;
		end else begin
			lat_new = lat_diff[LAT_W-1:0];
		end
	end

	// read the slot about to be overwritten at accept; data is back in ST_LOG
	assign ram_re = item_acc && (item.mode == MODE_LOG);
	assign ram_we = (state_q == ST_LOG);

	lae_ram #(
		.WIDTH (LAT_W),
		.DEPTH (WINDOW_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (lat_q),
		.re    (ram_re),
		.raddr (slot_q),
		.rdata (old_lat)
	);

	// evict the oldest entry only once the window is full
	always_comb begin
		full     = (cnt_q == CNT_W'(WINDOW_DEPTH));
		sum_drop = full ? SUM_W'(old_lat) : '0;
		sum_next = sum_q - sum_drop + SUM_W'(lat_q);
	end

	always_comb begin
		vel_u = vel_q;
		mag   = vel_q[POS_W-1] ? (~vel_u + POS_W'(1)) : vel_u;
		prod  = DQ_W'(mag) * DQ_W'(avg_q);
	end

	// truncation toward zero: divide the magnitude, then restore the sign
	always_comb begin
		q_dist  = quotient[Q_W-1:0];
		travel  = vel_q[POS_W-1] ? -$signed({2'b00, q_dist}) : $signed({2'b00, q_dist});
		pos_ext = ACC_W'(pos_q);
		pos_sum = pos_ext + travel;
		if (pos_sum > POS_MAX) begin
			pos_sat = POS_MAX[POS_W-1:0];
		end else if (pos_sum < POS_MIN) begin
			pos_sat = POS_MIN[POS_W-1:0];
		end else begin
			pos_sat = pos_sum[POS_W-1:0];
		end
	end

	always_comb begin
		div_req      = '0;
		div_dividend = '0;
		div_divisor  = '0;
		case (state_q)
			ST_AVG: begin
				if (cnt_q != '0) begin
					div_req.start = 1'b1;
					div_req.steps = STEP_W'(SUM_W);
					div_dividend  = {sum_q, {(DQ_W-SUM_W){1'b0}}};
					div_divisor   = DIV_W'(cnt_q);
				end
			end
			ST_MUL: begin
				div_req.start = 1'b1;
				div_req.steps = STEP_W'(DQ_W);
				div_dividend  = prod;
				div_divisor   = NS_PER_SEC;
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	lae_serdiv u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.sts      (div_sts),
		.quotient (quotient)
	);

	// control and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			sum_q       <= '0;
			cnt_q       <= '0;
			slot_q      <= '0;
			default_q   <= DEFAULT_LAT_RST;
		end else begin
			if (cfg_valid && cfg_ready) begin
				default_q <= cfg_data;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						state_q <= (item.mode == MODE_LOG) ? ST_LOG : ST_AVG;
					end
				end
				ST_LOG: begin
					sum_q <= sum_next;
					if (!full) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) begin
						slot_q <= '0;
					end else begin
						slot_q <= slot_q + SLOT_W'(1);
					end
					state_q <= ST_AVG;
				end
				ST_AVG: begin
					if (cnt_q != '0) begin
						state_q <= ST_AVGW;
					end else begin
						state_q <= (mode_q == MODE_PREDICT) ? ST_MUL : ST_DONE;
					end
				end
				ST_AVGW: begin
					if (div_sts.done) begin
						state_q <= (mode_q == MODE_PREDICT) ? ST_MUL : ST_DONE;
					end
				end
				ST_MUL: begin
					state_q <= ST_XW;
				end
				ST_XW: begin
					if (div_sts.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (item_acc) begin
			mode_q <= item.mode;
			pos_q  <= item.position_now;
			vel_q  <= item.velocity;
			lat_q  <= lat_new;
		end
		if (state_q == ST_AVG && cnt_q == '0) begin
			avg_q <= default_q;
		end else if (state_q == ST_AVGW && div_sts.done) begin
			avg_q <= quotient[LAT_W-1:0];
		end
		if (state_q == ST_XW && div_sts.done) begin
			pos_res_q <= pos_sat;
		end
		if (out_load) begin
			out_q.average_latency_ns <= avg_q;
			out_q.predicted_position <= (mode_q == MODE_PREDICT) ? pos_res_q : '0;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

[hdl/lae_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lae_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/lae_serdiv.sv]
// Radix-2 restoring divider, one quotient bit per cycle, dividend left aligned.
// Depends on lae_pkg.
module lae_serdiv (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lae_pkg::div_req_t            req,
	input  logic [lae_pkg::DQ_W-1:0]     dividend,
	input  logic [lae_pkg::DIV_W-1:0]    divisor,
	output lae_pkg::div_sts_t            sts,
	output logic [lae_pkg::DQ_W-1:0]     quotient
);
	import lae_pkg::*;

	logic [DIV_W-1:0]  rem_q;
	logic [DQ_W-1:0]   dq_q;
	logic [DIV_W-1:0]  div_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DIV_W:0]    trial;
	logic [DIV_W:0]    diff;
	logic              ge;
	logic [DIV_W-1:0]  rem_nxt;

	// remainder stays below the divisor, so trial < 2*divisor
	always_comb begin
		trial   = {rem_q, dq_q[DQ_W-1]};
		diff    = trial - {1'b0, div_q};
		ge      = trial >= {1'b0, div_q};
		rem_nxt = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= req.steps;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - STEP_W'(1);
			if (cnt_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			dq_q  <= {dq_q[DQ_W-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = dq_q;

endmodule

[hdl/lae_chk.sv]
// Port-level checker for latency_average_extrapolator, bound to the top level.
// Depends on lae_pkg.
module lae_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        item_valid,
	input logic                        item_ready,
	input logic                        result_valid,
	input logic                        result_ready,
	input lae_pkg::result_t            result
);
	import lae_pkg::*;

	logic [1:0] pend_q;
	logic       acc;
	logic       del;

	assign acc = item_valid && item_ready;
	assign del = result_valid && result_ready;

	// beats accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(acc) - 2'(del);
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat dropped or changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !item_ready)
		else $error("item taken while previous beat still in work");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two beats outstanding");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pend_q != 2'd0)
		else $error("result beat without a pending item");

endmodule

bind latency_average_extrapolator lae_chk u_lae_chk (.*);

[dv/lae_checker.sv]
// Checker for the latency average extrapolator: watches the item, result and
// config channels, predicts each result beat and compares it. Uses lae_pkg.
module lae_checker #(
	parameter int unsigned WINDOW_DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	input  logic                      item_ready,
	input  lae_pkg::item_t            item,
	input  logic                      result_valid,
	input  logic                      result_ready,
	input  lae_pkg::result_t          result,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [lae_pkg::LAT_W-1:0] cfg_data,
	output int unsigned               mismatches,
	output int unsigned               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import lae_pkg::*;

	logic [LAT_W-1:0] latency_window [WINDOW_DEPTH];
	logic [63:0]      window_sum;
	int unsigned      window_fill;
	int unsigned      next_slot;
	logic [LAT_W-1:0] default_ns;
	int unsigned      fails = 0;
	result_t          pending_results [$];

	// Applies one item beat to the window and returns the result it yields.
	function automatic result_t predict_latency_beat(item_t it);
		result_t            r;
		logic [63:0]        lat;
		logic [63:0]        mag;
		logic [63:0]        quot;
		logic signed [63:0] vel;
		logic signed [63:0] travel;
		logic signed [63:0] total;
		if (it.mode == MODE_LOG) begin
			lat = (it.arrival_ts >= it.capture_ts) ?
				it.arrival_ts - it.capture_ts : 64'd0;
			if (lat > 64'hFFFF_FFFF)
				lat = 64'hFFFF_FFFF;
			// full window: the oldest latency leaves the sum
			if (window_fill >= WINDOW_DEPTH)
				window_sum = window_sum - 64'(latency_window[next_slot]);
			else
				window_fill++;
			latency_window[next_slot] = lat[LAT_W-1:0];
			window_sum = window_sum + lat;
			next_slot = (next_slot + 1) % WINDOW_DEPTH;
		end
		r.average_latency_ns = (window_fill == 0) ? default_ns :
			LAT_W'(window_sum / 64'(window_fill));
		r.predicted_position = '0;
		if (it.mode == MODE_PREDICT) begin
			vel = $signed(it.velocity);
			mag = (vel < 0) ? -vel : vel;
			quot = (mag * 64'(r.average_latency_ns)) / 64'(NS_PER_SEC);
			travel = (vel < 0) ? -$signed(quot) : $signed(quot);
			total = $signed(it.position_now);
			total = total + travel;
			if (total > 64'sd2147483647)
				total = 64'sd2147483647;
			else if (total < -64'sd2147483648)
				total = -64'sd2147483648;
			r.predicted_position = total[POS_W-1:0];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			window_sum = '0;
			window_fill = 0;
			next_slot = 0;
			default_ns = DEFAULT_LAT_RST;
			pending_results.delete();
			outstanding <= 0;
			mismatches <= fails;
		end else begin
			if (result_valid && result_ready) begin
				if (pending_results.size() == 0) begin
					$error("result beat with no item pending: avg %0d, pos %0d",
						result.average_latency_ns, $signed(result.predicted_position));
					fails++;
				end else begin
					want = pending_results[0];
					pending_results.delete(0);
					if (result.average_latency_ns !== want.average_latency_ns) begin
						$error("average_latency_ns: expected %0d, actual %0d",
							want.average_latency_ns, result.average_latency_ns);
						fails++;
					end
					if (result.predicted_position !== want.predicted_position) begin
						$error("predicted_position: expected %0d, actual %0d",
							$signed(want.predicted_position), $signed(result.predicted_position));
						fails++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				default_ns = cfg_data;
			if (item_valid && item_ready)
				pending_results.insert(pending_results.size(), predict_latency_beat(item));
			outstanding <= pending_results.size();
			mismatches <= fails;
		end
	end

endmodule

[dv/tb.sv]
// Top of the latency average extrapolator bench: clock, reset, item and config
// stimulus, result back-pressure and the verdict. Uses lae_pkg and lae_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lae_pkg::*;

	localparam int unsigned WINDOW          = 64;
	localparam int unsigned RANDOM_ITEMS    = 1350;
	localparam int unsigned PHASE_COUNT     = 8;
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	// the slowest beat is a predict beat; leave time for it at the end
	localparam int unsigned DRAIN_CYCLES    = 300;
	// ~1400 beats, each with its busy time plus long gaps and long stalls, several times over
	localparam int unsigned CYCLE_LIMIT     = 1000000;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_e;

	// latency shapes for log beats
	typedef enum int {
		LAT_SMALL,
		LAT_TYPICAL,
		LAT_NEAR_MAX,
		LAT_OVER,
		LAT_NEGATIVE,
		LAT_WILD
	} lat_class_e;

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_ready;
	item_t            item;
	logic             result_valid;
	logic             result_ready;
	result_t          result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [LAT_W-1:0] cfg_data;
	int unsigned      mismatches;
	int unsigned      outstanding;
	int unsigned      cycle_count = 0;

	// shared between the sender and the receiver process
	idle_mode_e       idle_mode = IDLE_NONE;
	int unsigned      idle_pct = 82;
	logic             hold_off_req = 1'b0;

	latency_average_extrapolator #(
		.WINDOW_DEPTH(WINDOW)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	lae_checker #(
		.WINDOW_DEPTH(WINDOW)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// watchdog: a hung handshake ends the run here
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("status: fail");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Q16.16 value: mostly full range, some small, a few at the rails
	function automatic logic signed [POS_W-1:0] q16_value();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			1, 2, 3: return $signed(32'($urandom_range(0, 32'h001F_FFFF))) - 32'sh0010_0000;
			default: return $signed($urandom);
		endcase
	endfunction

	// log beat; the position fields are don't-care in this mode, so randomize them
	function automatic item_t log_beat(logic [TS_W-1:0] cap, logic [TS_W-1:0] inp);
		item_t it;
		it.mode = MODE_LOG;
		it.capture_ts = cap;
		it.arrival_ts = inp;
		it.position_now = $urandom;
		it.velocity = $urandom;
		return it;
	endfunction

	// predict beat; timestamps are don't-care here
	function automatic item_t predict_beat(logic signed [POS_W-1:0] pos,
			logic signed [POS_W-1:0] vel);
		item_t it;
		it.mode = MODE_PREDICT;
		it.capture_ts = rand64();
		it.arrival_ts = rand64();
		it.position_now = pos;
		it.velocity = vel;
		return it;
	endfunction

	// Offer one beat and return on the edge that takes it. Valid is left high so
	// back-to-back beats keep it asserted; only one NBA per signal per step.
	task automatic drive_item(input item_t it);
		if (idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) begin
			while ($urandom_range(0, 99) < idle_pct) begin
				item_valid <= 1'b0;
				@(posedge clk);
			end
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
	endtask

	// Drop valid and wait until every result beat is back. The checker count
	// is registered, hence the edge before the first look.
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// default register is written only with the block idle
	task automatic write_default(input logic [LAT_W-1:0] value);
		drain();
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Receiver: ready follows the current idle mode; once, on request, it holds
	// off for a long stretch so the result register fills and input stalls.
	initial begin
		logic        taken;
		int unsigned n;
		taken = 1'b0;
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req && !taken) begin
				taken = 1'b1;
				result_ready <= 1'b0;
				for (n = 0; n < HOLD_OFF_CYCLES; n++)
					@(posedge clk);
			end else if (idle_mode == IDLE_RECEIVER || idle_mode == IDLE_BOTH) begin
				result_ready <= ($urandom_range(0, 99) >= idle_pct);
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin
		item_t       it;
		lat_class_e  profile;
		lat_class_e  cls;
		logic [63:0] cap;
		logic [63:0] delta;

		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed: empty window first, so the default register shows ----
		// reset default of 50 ms with max velocity
		drive_item(predict_beat(32'sh0001_0000, 32'sh7FFF_FFFF));
		// zero default: no distance at all
		write_default('0);
		drive_item(predict_beat(32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
		// max default: overflow both ways, opposite signs, truncation toward zero
		write_default('1);
		drive_item(predict_beat(32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
		drive_item(predict_beat(32'sh8000_0000, 32'sh8000_0000));
		drive_item(predict_beat(32'sh8000_0000, 32'sh7FFF_FFFF));
		drive_item(predict_beat(32'sh0000_0000, -32'sd3));
		write_default($urandom);
		drive_item(predict_beat(q16_value(), q16_value()));

		// log beats: zero latency, negative latency clamps, exact and over 32-bit max
		drive_item(log_beat(64'd0, 64'd0));
		drive_item(log_beat('1, '1));
		drive_item(log_beat(64'd0, '1));
		drive_item(log_beat(64'd100, 64'd50));
		drive_item(log_beat(64'd1000, 64'd1000 + 64'hFFFF_FFFF));
		drive_item(log_beat(64'd5, 64'd5 + 64'h1_0000_0000));
		drive_item(log_beat(64'hFFFF_FFFF_0000_0000, '1));
		drive_item(log_beat('1, 64'd0));
		// predictions against a large window average
		drive_item(predict_beat(32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
		drive_item(predict_beat(32'sh8000_0000, 32'sh8000_0000));
		drive_item(predict_beat(32'sh1234_5678, -32'sh0001_8000));
		drive_item(log_beat(64'd12_345, 64'd12_345 + 64'd16_666_667));
		drive_item(predict_beat(-32'sh0004_0000, 32'sh0010_0000));

		// ---- random phases, one idle mode each, default rewritten between ----
		for (int p = 0; p < PHASE_COUNT; p++) begin
			idle_mode = idle_mode_e'(p % 4);
			idle_pct = (idle_mode == IDLE_BOTH) ? 14 : 82;
			case (p % 4)
				0: write_default($urandom);
				1: write_default('0);
				2: write_default('1);
				default: write_default(DEFAULT_LAT_RST);
			endcase
			// each phase leans on one latency shape, so the average can
			// drift to the extremes once the window has turned over
			profile = lat_class_e'($urandom_range(0, 5));
			for (int n = 0; n < RANDOM_ITEMS / PHASE_COUNT; n++) begin
				// first phase has no idling: stall results while beats keep coming
				if (p == 0 && n == 20)
					hold_off_req = 1'b1;
				if ($urandom_range(0, 1) == 0) begin
					cls = ($urandom_range(0, 9) < 7) ? profile :
						lat_class_e'($urandom_range(0, 5));
					cap = rand64();
					case (cls)
						LAT_SMALL:    delta = 64'($urandom_range(0, 1000));
						LAT_TYPICAL:  delta = 64'($urandom_range(1_000_000, 200_000_000));
						LAT_NEAR_MAX: delta = 64'hFFFF_FFFF - 64'($urandom_range(0, 1000));
						LAT_OVER:     delta = rand64() | 64'h1_0000_0000;
						LAT_NEGATIVE: delta = -(64'd1 + 64'($urandom));
						default:      delta = rand64();
					endcase
					it = log_beat(cap, cap + delta);
				end else begin
					it = predict_beat(q16_value(), q16_value());
				end
				drive_item(it);
			end
		end

		// ---- wind down and give the verdict ----
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
